[rtl/mrss_pkg.sv]
// shared types and constants for the multi-ring sample statistics block
package mrss_pkg;

    localparam int FUNC_W      = 2;
    localparam int BKT_W       = 2;
    localparam int SMP_W       = 32;
    localparam int OFF_W       = 7;
    localparam int CNT_W       = 7;
    localparam int MAX_BUCKETS = 4;

    // 1000.0 in unsigned q16.16
    localparam logic [SMP_W-1:0] MIN_START = 32'h03E8_0000;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_STATS = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_PUSH,
        S_RD_ADD,
        S_RD_MOD,
        S_RD_WAIT,
        S_ST_INIT,
        S_ST_WALK,
        S_ST_DRAIN,
        S_ST_DIV,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic clr;
        logic load;
        logic push;
        logic rd_add;
        logic rd_mod;
        logic rd_issue;
        logic rd_cap;
        logic st_init;
        logic st_issue;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  clr_last;
        logic  bucket_ok;
        logic  idx_ge;
        logic  empty;
        logic  walk_last;
        logic  div_last;
        logic  out_free;
    } t_status;

endpackage

[rtl/mrss_ram.sv]
// generic single-write, single-read ram with registered read data
module mrss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mrss_dp.sv]
// datapath: ring pointers, sample store, min/max/sum walk, serial divider, result register
module mrss_dp #(
    parameter int RING_SLOTS = 128,
    parameter int NUM_RINGS  = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mrss_pkg::FUNC_W-1:0]   i_func,
    input  logic [mrss_pkg::BKT_W-1:0]    i_bucket,
    input  logic [mrss_pkg::SMP_W-1:0]    i_sample_in,
    input  logic [mrss_pkg::OFF_W-1:0]    i_offset,
    input  mrss_pkg::t_cmd                i_cmd,
    output mrss_pkg::t_status             o_status,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [mrss_pkg::CNT_W-1:0]    o_count,
    output logic [mrss_pkg::SMP_W-1:0]    o_sample_out,
    output logic [mrss_pkg::SMP_W-1:0]    o_minimum,
    output logic [mrss_pkg::SMP_W-1:0]    o_maximum,
    output logic [mrss_pkg::SMP_W-1:0]    o_average
);

    import mrss_pkg::*;

    // only rings reachable through the bucket field get storage
    localparam int NR_USED = (NUM_RINGS < MAX_BUCKETS) ? NUM_RINGS : MAX_BUCKETS;
    localparam int PW      = $clog2(RING_SLOTS);
    localparam int RIW     = (NR_USED > 1) ? $clog2(NR_USED) : 1;
    localparam int DEPTH   = NR_USED * RING_SLOTS;
    localparam int AW      = $clog2(DEPTH);
    localparam int IW      = ((PW > OFF_W) ? PW : OFF_W) + 1;
    localparam int SW      = SMP_W + PW;
    localparam int DCW     = $clog2(SW);

    localparam logic [PW-1:0]  LAST_SLOT = PW'(RING_SLOTS - 1);
    localparam logic [PW:0]    SLOTS_X   = (PW + 1)'(RING_SLOTS);
    localparam logic [IW-1:0]  SLOTS_I   = IW'(RING_SLOTS);
    localparam logic [AW-1:0]  SLOTS_A   = AW'(RING_SLOTS);
    localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [DCW-1:0] DIV_LAST  = DCW'(SW - 1);
    localparam logic [2:0]     RINGS_X   = 3'(NR_USED);

    // latched item
    t_func                r_func;
    logic [BKT_W-1:0]     r_bucket;
    logic [SMP_W-1:0]     r_sample;
    logic [OFF_W-1:0]     r_offset;

    logic [PW-1:0]        r_wp [NR_USED];
    logic [PW-1:0]        r_op [NR_USED];

    logic [IW-1:0]        r_idx;
    logic [PW-1:0]        r_i;
    logic [PW-1:0]        r_n;
    logic [SMP_W-1:0]     r_min;
    logic [SMP_W-1:0]     r_max;
    logic [SW-1:0]        r_sum;
    logic [PW-1:0]        r_rem;
    logic [DCW-1:0]       r_dcnt;
    logic                 r_acc_v;
    logic [AW-1:0]        r_clr_addr;
    logic [SMP_W-1:0]     r_rd_data;

    logic                 r_ovalid;
    logic [CNT_W-1:0]     r_count;
    logic [SMP_W-1:0]     r_sample_out;
    logic [SMP_W-1:0]     r_minimum;
    logic [SMP_W-1:0]     r_maximum;
    logic [SMP_W-1:0]     r_average;

    logic                 bucket_ok;
    logic [RIW-1:0]       ring;
    logic [PW-1:0]        wp;
    logic [PW-1:0]        op;
    logic [PW:0]          diff;
    logic [PW:0]          cnt_wrap;
    logic [PW-1:0]        cnt;
    logic [PW-1:0]        wp_inc;
    logic [PW-1:0]        op_inc;
    logic [AW-1:0]        base;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [PW-1:0]        slot;
    logic [PW-1:0]        slot_inc;
    logic [IW-1:0]        idx_add;
    logic                 idx_ge;
    logic [PW:0]          rem_sh;
    logic [PW:0]          n_x;
    logic [PW:0]          rem_sub;
    logic                 q_bit;
    logic                 stats_ok;
    logic                 out_free;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [SMP_W-1:0]     ram_wdata;
    logic                 ram_re;
    logic [SMP_W-1:0]     ram_rdata;

    assign bucket_ok = {1'b0, r_bucket} < RINGS_X;
    assign ring      = bucket_ok ? r_bucket[RIW-1:0] : '0;
    assign wp        = r_wp[ring];
    assign op        = r_op[ring];

    // held samples, write pointer minus oldest pointer modulo ring size
    assign diff     = {1'b0, wp} - {1'b0, op};
    assign cnt_wrap = diff + SLOTS_X;
    assign cnt      = diff[PW] ? cnt_wrap[PW-1:0] : diff[PW-1:0];

    assign wp_inc = (wp == LAST_SLOT) ? '0 : wp + 1'b1;
    assign op_inc = (op == LAST_SLOT) ? '0 : op + 1'b1;

    assign base     = AW'(ring) * SLOTS_A;
    assign wr_addr  = base + AW'(wp);
    assign slot     = r_idx[PW-1:0];
    assign slot_inc = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
    assign rd_addr  = base + AW'(slot);

    assign idx_add = IW'(op) + IW'(r_offset);
    assign idx_ge  = r_idx >= SLOTS_I;

    // restoring divider step, one quotient bit per cycle
    assign rem_sh  = {r_rem, r_sum[SW-1]};
    assign n_x     = {1'b0, r_n};
    assign rem_sub = rem_sh - n_x;
    assign q_bit   = rem_sh >= n_x;

    assign stats_ok = bucket_ok && (r_func == FUNC_STATS) && (cnt != '0);
    assign out_free = !r_ovalid || !i_stall;

    assign ram_we    = i_cmd.clr || i_cmd.push;
    assign ram_waddr = i_cmd.clr ? r_clr_addr : wr_addr;
    assign ram_wdata = i_cmd.clr ? '0 : r_sample;
    assign ram_re    = i_cmd.rd_issue || i_cmd.st_issue;

    mrss_ram #(
        .WIDTH (SMP_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NR_USED; k++) begin
                r_wp[k] <= '0;
                r_op[k] <= '0;
            end
            r_acc_v    <= 1'b0;
            r_clr_addr <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_acc_v <= i_cmd.st_issue;
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.push) begin
                r_wp[ring] <= wp_inc;
                // full ring drops its oldest sample
                if (wp_inc == op) begin
                    r_op[ring] <= op_inc;
                end
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= t_func'(i_func);
            r_bucket <= i_bucket;
            r_sample <= i_sample_in;
            r_offset <= i_offset;
        end

        if (i_cmd.rd_add) begin
            r_idx <= idx_add;
        end else if (i_cmd.rd_mod) begin
            r_idx <= r_idx - SLOTS_I;
        end else if (i_cmd.st_init) begin
            r_idx <= IW'(op);
        end else if (i_cmd.st_issue) begin
            r_idx <= IW'(slot_inc);
        end

        if (i_cmd.rd_cap) begin
            r_rd_data <= ram_rdata;
        end

        if (i_cmd.st_init) begin
            r_i    <= '0;
            r_n    <= cnt;
            r_min  <= MIN_START;
            r_max  <= '0;
            r_rem  <= '0;
            r_dcnt <= '0;
        end else begin
            if (i_cmd.st_issue) begin
                r_i <= r_i + 1'b1;
            end
            if (r_acc_v) begin
                if (ram_rdata < r_min) begin
                    r_min <= ram_rdata;
                end
                if (ram_rdata > r_max) begin
                    r_max <= ram_rdata;
                end
            end
            if (i_cmd.div_step) begin
                r_rem  <= q_bit ? rem_sub[PW-1:0] : rem_sh[PW-1:0];
                r_dcnt <= r_dcnt + 1'b1;
            end
        end

        // sum register turns into the quotient as the divider shifts
        if (i_cmd.st_init) begin
            r_sum <= '0;
        end else if (r_acc_v) begin
            r_sum <= r_sum + SW'(ram_rdata);
        end else if (i_cmd.div_step) begin
            r_sum <= {r_sum[SW-2:0], q_bit};
        end

        if (i_cmd.out_load) begin
            r_count      <= bucket_ok ? CNT_W'(cnt) : '0;
            r_sample_out <= (bucket_ok && r_func == FUNC_READ) ? r_rd_data : '0;
            r_minimum    <= stats_ok ? r_min : '0;
            r_maximum    <= stats_ok ? r_max : '0;
            r_average    <= stats_ok ? r_sum[SMP_W-1:0] : '0;
        end
    end

    always_comb begin
        o_status.func      = r_func;
        o_status.clr_last  = r_clr_addr == LAST_ADDR;
        o_status.bucket_ok = bucket_ok;
        o_status.idx_ge    = idx_ge;
        o_status.empty     = cnt == '0;
        o_status.walk_last = r_i == (r_n - 1'b1);
        o_status.div_last  = r_dcnt == DIV_LAST;
        o_status.out_free  = out_free;
    end

    assign o_valid      = r_ovalid;
    assign o_count      = r_count;
    assign o_sample_out = r_sample_out;
    assign o_minimum    = r_minimum;
    assign o_maximum    = r_maximum;
    assign o_average    = r_average;

endmodule

[rtl/mrss_ctrl.sv]
// controller: sequences clear sweep, push, read, statistics walk and divide
module mrss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  mrss_pkg::t_status i_status,
    output mrss_pkg::t_cmd    o_cmd
);

    import mrss_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_status.bucket_ok) begin
                    n_state = S_FINISH;
                end else begin
                    unique case (i_status.func)
                        FUNC_PUSH:  n_state = S_PUSH;
                        FUNC_READ:  n_state = S_RD_ADD;
                        FUNC_STATS: n_state = S_ST_INIT;
                        FUNC_NONE:  n_state = S_FINISH;
                        default:    n_state = S_FINISH;
                    endcase
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_FINISH;
            end
            S_RD_ADD: begin
                o_cmd.rd_add = 1'b1;
                n_state      = S_RD_MOD;
            end
            S_RD_MOD: begin
                // bring oldest + offset back into the ring
                if (i_status.idx_ge) begin
                    o_cmd.rd_mod = 1'b1;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_RD_WAIT;
                end
            end
            S_RD_WAIT: begin
                o_cmd.rd_cap = 1'b1;
                n_state      = S_FINISH;
            end
            S_ST_INIT: begin
                o_cmd.st_init = 1'b1;
                n_state       = i_status.empty ? S_FINISH : S_ST_WALK;
            end
            S_ST_WALK: begin
                o_cmd.st_issue = 1'b1;
                if (i_status.walk_last) begin
                    n_state = S_ST_DRAIN;
                end
            end
            S_ST_DRAIN: begin
                n_state = S_ST_DIV;
            end
            S_ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = r_state != S_IDLE;

endmodule

[rtl/multi_ring_sample_statistics.sv]
// top level: ring buffers of q16.16 timing samples with min, max and mean
// Keeps up to four overwriting rings of RING_SLOTS slots each (one slot always unused)
// in a single-port-write, registered-read store of min(NUM_RINGS,4)*RING_SLOTS words.
// After reset the store is cleared one word per cycle, min(NUM_RINGS,4)*RING_SLOTS words
// (512 by default), with o_stall high. Items are processed one at a time from input accept
// to result: a push writes the store and advances the write pointer, a read adds offset to
// oldest, subtracts the ring size as often as needed to wrap it and reads the store, and
// stats read the store once per held sample, then produce one quotient bit per cycle of the
// serial divider. A result waits in the output register while the next item is accepted.
module multi_ring_sample_statistics #(
    parameter int RING_SLOTS = 128,
    parameter int NUM_RINGS  = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [mrss_pkg::FUNC_W-1:0]   i_func,
    input  logic [mrss_pkg::BKT_W-1:0]    i_bucket,
    input  logic [mrss_pkg::SMP_W-1:0]    i_sample_in,
    input  logic [mrss_pkg::OFF_W-1:0]    i_offset,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [mrss_pkg::CNT_W-1:0]    o_count,
    output logic [mrss_pkg::SMP_W-1:0]    o_sample_out,
    output logic [mrss_pkg::SMP_W-1:0]    o_minimum,
    output logic [mrss_pkg::SMP_W-1:0]    o_maximum,
    output logic [mrss_pkg::SMP_W-1:0]    o_average
);

    import mrss_pkg::*;

    t_cmd    cmd;
    t_status status;

    mrss_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mrss_dp #(
        .RING_SLOTS (RING_SLOTS),
        .NUM_RINGS  (NUM_RINGS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_func       (i_func),
        .i_bucket     (i_bucket),
        .i_sample_in  (i_sample_in),
        .i_offset     (i_offset),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_count      (o_count),
        .o_sample_out (o_sample_out),
        .o_minimum    (o_minimum),
        .o_maximum    (o_maximum),
        .o_average    (o_average)
    );

endmodule
